@@ rtl/phrb_pkg.sv @@
// Shared types and constants for the positioned history ring buffer.
package phrb_pkg;

  localparam int unsigned POS_W  = 48;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned BYTE_W = 8;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an input beat
    logic append;    // store the byte and emit the write result
    logic query;     // emit the query answer
    logic rd_a;      // read setup, first step
    logic rd_b;      // read setup, second step
    logic rd_c;      // read setup, third step
    logic rd_empty;  // emit the empty read result
    logic rd_issue;  // start a store read for the next byte
    logic rd_emit;   // move the read byte into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic out_free;
    logic cnt_zero;
    logic cnt_last;
  } status_t;

endpackage

@@ rtl/phrb_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module phrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/phrb_ctrl.sv @@
// Controller state machine for the positioned history ring buffer.
module phrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  phrb_pkg::status_t status_i,
  output phrb_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_B,
    S_RD_C,
    S_RD_ADDR,
    S_RD_DATA
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status_i.op)
          phrb_pkg::OP_APPEND: begin
            if (status_i.out_free) begin
              cmd_o.append = 1'b1;
              state_d      = S_IDLE;
            end
          end
          phrb_pkg::OP_QUERY: begin
            if (status_i.out_free) begin
              cmd_o.query = 1'b1;
              state_d     = S_IDLE;
            end
          end
          phrb_pkg::OP_READ: begin
            cmd_o.rd_a = 1'b1;
            state_d    = S_RD_B;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_RD_C;
      end
      S_RD_C: begin
        cmd_o.rd_c = 1'b1;
        state_d    = S_RD_ADDR;
      end
      S_RD_ADDR: begin
        if (status_i.cnt_zero) begin
          if (status_i.out_free) begin
            cmd_o.rd_empty = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        // Emit one byte per cycle while the output is free, and fetch the next one alongside it.
        if (status_i.out_free) begin
          cmd_o.rd_emit = 1'b1;
          if (status_i.cnt_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/phrb_dp.sv @@
// Datapath of the positioned history ring buffer: position state, read setup and output register.
module phrb_dp #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned READ_BURST = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  phrb_pkg::cmd_t                   cmd_i,
  output phrb_pkg::status_t                status_o,
  input  logic [1:0]                       opcode_i,
  input  logic [phrb_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic [phrb_pkg::POS_W-1:0]       position_i,
  input  logic [phrb_pkg::LEN_W-1:0]       length_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [phrb_pkg::BYTE_W-1:0]      data_out_o,
  output logic                             last_o,
  output logic                             displaced_o,
  output logic                             range_held_o,
  output logic [phrb_pkg::POS_W-1:0]       end_position_o
);

  localparam int unsigned POS_W  = phrb_pkg::POS_W;
  localparam int unsigned LEN_W  = phrb_pkg::LEN_W;
  localparam int unsigned BYTE_W = phrb_pkg::BYTE_W;
  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;
  localparam int unsigned CNT_W  = $clog2(READ_BURST + 1);
  localparam int unsigned MIN_W  = (LEN_W > FILL_W) ? LEN_W : FILL_W;

  // Buffer state.
  logic [POS_W-1:0]  old_q, old_d;
  logic [IDX_W-1:0]  oi_q, oi_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Captured input beat.
  phrb_pkg::op_e     op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [POS_W-1:0]  pos_q;
  logic [LEN_W-1:0]  len_q;

  // Read setup and read loop registers.
  logic              before_q;
  logic [POS_W-1:0]  diff_q, relp_q;
  logic [LEN_W-1:0]  n1_q;
  logic [FILL_W-1:0] avail_q;
  logic [IDX_W-1:0]  relidx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  rd_slot_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              last_q, last_d;
  logic              disp_q, disp_d;
  logic              held_q, held_d;
  logic [POS_W-1:0]  endp_q, endp_d;

  logic              out_free;
  logic              full;
  logic [SUM_W-1:0]  wsum, wslot, rsum, rslot;
  logic [IDX_W-1:0]  waddr, oi_inc, slot_inc;
  logic [POS_W-1:0]  end_cur, end_next;
  logic              held;
  logic [LEN_W-1:0]  n1_d;
  logic [POS_W-1:0]  rel0;
  logic [FILL_W-1:0] avail_d;
  logic [MIN_W-1:0]  m_min;
  logic [CNT_W-1:0]  cnt_c;
  logic [BYTE_W-1:0] rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  // Append addressing: overwrite the oldest slot when full, else the slot after the newest.
  assign full     = (fill_q == FILL_W'(CAPACITY));
  assign wsum     = SUM_W'(oi_q) + SUM_W'(fill_q);
  assign wslot    = (wsum >= SUM_W'(CAPACITY)) ? wsum - SUM_W'(CAPACITY) : wsum;
  assign waddr    = full ? oi_q : wslot[IDX_W-1:0];
  assign oi_inc   = (oi_q == IDX_W'(CAPACITY - 1)) ? '0 : oi_q + 1'b1;
  assign end_cur  = old_q + POS_W'(fill_q);
  assign end_next = end_cur + 1'b1;

  // Query: the range lies between the oldest position and the unwrapped data end.
  assign held = (pos_q >= old_q) &&
                (({1'b0, pos_q} + (POS_W + 1)'(len_q)) <=
                 ({1'b0, old_q} + (POS_W + 1)'(fill_q)));

  // Read setup, second step: drop the skipped part and measure the bytes held after the start.
  always_comb begin
    if (before_q) begin
      n1_d = (diff_q >= POS_W'(len_q)) ? '0 : len_q - diff_q[LEN_W-1:0];
      rel0 = '0;
    end else begin
      n1_d = len_q;
      rel0 = relp_q;
    end
    avail_d = (rel0 < POS_W'(fill_q)) ? fill_q - rel0[FILL_W-1:0] : '0;
  end

  // Read setup, third step: clip to the data held and to the burst limit.
  assign m_min = (MIN_W'(n1_q) < MIN_W'(avail_q)) ? MIN_W'(n1_q) : MIN_W'(avail_q);
  assign cnt_c = (m_min > MIN_W'(READ_BURST)) ? CNT_W'(READ_BURST) : m_min[CNT_W-1:0];
  assign rsum  = SUM_W'(oi_q) + SUM_W'(relidx_q);
  assign rslot = (rsum >= SUM_W'(CAPACITY)) ? rsum - SUM_W'(CAPACITY) : rsum;
  assign slot_inc = (rd_slot_q == IDX_W'(CAPACITY - 1)) ? '0 : rd_slot_q + 1'b1;

  // Buffer state update on append.
  always_comb begin
    old_d  = old_q;
    oi_d   = oi_q;
    fill_d = fill_q;
    if (cmd_i.append) begin
      if (full) begin
        old_d = old_q + 1'b1;
        oi_d  = oi_inc;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // Output register next value.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    data_d      = data_q;
    last_d      = last_q;
    disp_d      = disp_q;
    held_d      = held_q;
    endp_d      = endp_q;
    if (cmd_i.append || cmd_i.query || cmd_i.rd_empty || cmd_i.rd_emit) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      last_d      = 1'b1;
      disp_d      = 1'b0;
      held_d      = 1'b0;
      endp_d      = end_cur;
      priority if (cmd_i.append) begin
        kind_d = phrb_pkg::KIND_WRITE;
        disp_d = full;
        endp_d = end_next;
      end else if (cmd_i.query) begin
        kind_d = phrb_pkg::KIND_QUERY;
        held_d = held;
      end else if (cmd_i.rd_empty) begin
        kind_d = phrb_pkg::KIND_EMPTY;
      end else begin
        kind_d = phrb_pkg::KIND_BYTE;
        data_d = rdata;
        last_d = (cnt_q == CNT_W'(1));
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q       <= '0;
      oi_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      old_q       <= old_d;
      oi_q        <= oi_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= phrb_pkg::op_e'(opcode_i);
      byte_q <= data_byte_i;
      pos_q  <= position_i;
      len_q  <= length_i;
    end
    if (cmd_i.rd_a) begin
      before_q <= (pos_q < old_q);
      diff_q   <= old_q - pos_q;
      relp_q   <= pos_q - old_q;
    end
    if (cmd_i.rd_b) begin
      n1_q     <= n1_d;
      avail_q  <= avail_d;
      relidx_q <= rel0[IDX_W-1:0];
    end
    if (cmd_i.rd_c) begin
      cnt_q     <= cnt_c;
      rd_slot_q <= rslot[IDX_W-1:0];
    end else begin
      if (cmd_i.rd_emit) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.rd_issue) begin
        rd_slot_q <= slot_inc;
      end
    end
    kind_q <= kind_d;
    data_q <= data_d;
    last_q <= last_d;
    disp_q <= disp_d;
    held_q <= held_d;
    endp_q <= endp_d;
  end

  // Byte store.
  phrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_slot_q),
    .rdata_o (rdata)
  );

  // Status toward the controller.
  assign status_o.op       = op_q;
  assign status_o.out_free = out_free;
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_last = (cnt_q == CNT_W'(1));

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_out_o     = data_q;
  assign last_o         = last_q;
  assign displaced_o    = disp_q;
  assign range_held_o   = held_q;
  assign end_position_o = endp_q;

endmodule

@@ rtl/positioned_history_ring_buffer_top.sv @@
// Top level of the positioned history ring buffer.
//
// Keeps the newest CAPACITY bytes of a stream, addressed by absolute position.
// Input beats (in_valid_i / in_stall_o) carry an opcode: append a byte, read a
// range, or query whether a range is held. Result beats (out_valid_o /
// out_stall_i) leave through an output register.
// One item is handled at a time; in_stall_o is high while an item is at work.
// Append and query: one result, written to the output register once the output
// is free; the next item is taken after that result has been registered.
// Read: the setup steps (rd_a, rd_b, rd_c) and a step to address the byte store,
// then one byte per cycle while the output is not stalled, from its single
// registered read port, which sets that rate; up to READ_BURST byte results, the
// last one marked with last_o; the next item is taken after it has been registered.
// An empty read gives its one result, of the empty kind.
// A stall on the output holds the current result and pauses the read loop.
// Reset empties the buffer and sets the oldest position to zero; the byte store
// itself is not cleared and needs no clearing pass.
module positioned_history_ring_buffer_top #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned READ_BURST = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [phrb_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [phrb_pkg::POS_W-1:0]  position_i,
  input  logic [phrb_pkg::LEN_W-1:0]  length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [phrb_pkg::BYTE_W-1:0] data_out_o,
  output logic                        last_o,
  output logic                        displaced_o,
  output logic                        range_held_o,
  output logic [phrb_pkg::POS_W-1:0]  end_position_o
);

  phrb_pkg::cmd_t    cmd;
  phrb_pkg::status_t status;

  // Sequencer.
  phrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath with the byte store.
  phrb_dp #(
    .CAPACITY   (CAPACITY),
    .READ_BURST (READ_BURST)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .position_i     (position_i),
    .length_i       (length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_out_o     (data_out_o),
    .last_o         (last_o),
    .displaced_o    (displaced_o),
    .range_held_o   (range_held_o),
    .end_position_o (end_position_o)
  );

endmodule
